>>> sv/gps_pkg.sv
package gps_pkg;

    localparam int GrainLengthDef = 1024;
    localparam int GrainCountDef  = 4;
    localparam int RingDepthDef   = 16384;
    localparam int CfgWidth       = 15;
    localparam int SampleWidth    = 24;
    localparam int RatioWidth     = 20;
    localparam int WinWidth       = 17;
    localparam logic [CfgWidth-1:0] RingLengthReset = 15'd9600;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PREP,
        ST_GRAIN,
        ST_READ,
        ST_WAIT,
        ST_CAPT,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_MUL5,
        ST_MUL6,
        ST_MUL7,
        ST_MUL8,
        ST_MUL9,
        ST_NEXT,
        ST_OUT
    } state_t;

    // Hann window entry in unsigned Q1.16, built bit-exact with 64-bit arithmetic.
    function automatic logic [WinWidth-1:0] hann_entry(input int unsigned i, input int unsigned g);
        logic [63:0] p;
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] w;
        p = (64'(i) << 30) / 64'(g - 1);
        u = (p > 64'd536870912) ? (64'd1073741824 - p) : p;
        z = u << 1;
        z2 = (z * z) >> 30;
        acc = 64'd5026994 - ((z2 * 64'd172273) >> 30);
        acc = 64'd85569306 - ((z2 * acc) >> 30);
        acc = 64'd693598670 - ((z2 * acc) >> 30);
        acc = 64'd1686629713 - ((z2 * acc) >> 30);
        s = (z * acc) >> 30;
        w = (s * s + (64'd1 << 43)) >> 44;
        if (w > 64'd65536)
        begin
            w = 64'd65536;
        end
        return w[WinWidth-1:0];
    endfunction

endpackage

>>> sv/granular_pitch_shifter.sv
// One item at a time: no new input item is accepted until the result of the last one is
// loaded into the output register; one shared 32 x 32 multiplier, six products per grain,
// and the single ring read port set the pace.
// Reset: asynchronous, active low; after reset a clearing pass zeroes every ring entry,
// during which no input item is accepted.
module granular_pitch_shifter #(
    parameter int GRAIN_LENGTH = gps_pkg::GrainLengthDef,
    parameter int GRAIN_COUNT  = gps_pkg::GrainCountDef,
    parameter int RING_DEPTH   = gps_pkg::RingDepthDef
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gps_pkg::CfgWidth-1:0]           ring_length,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [gps_pkg::SampleWidth-1:0] sample_in,
    input  logic signed [gps_pkg::RatioWidth-1:0]  pitch_ratio,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [gps_pkg::SampleWidth-1:0] sample_out
);
    import gps_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = AW + 1;
    localparam int PW = AW + 16;
    localparam int SPW = PW + 2;
    localparam int AGW = $clog2(GRAIN_LENGTH) + 1;
    localparam int HW = $clog2(GRAIN_LENGTH);
    localparam int GW = (GRAIN_COUNT > 1) ? $clog2(GRAIN_COUNT) : 1;
    localparam int SCW = $clog2(GRAIN_LENGTH / 2) + 1;
    localparam int SW = 64;

    logic [WinWidth-1:0] hann_rom [GRAIN_LENGTH];
    always_comb
    begin
        for (int i = 0; i < GRAIN_LENGTH; i++)
        begin
            hann_rom[i] = hann_entry(i, GRAIN_LENGTH);
        end
    end

    logic signed [SampleWidth-1:0] ring_mem [RING_DEPTH];
    logic signed [SampleWidth-1:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [CfgWidth-1:0] rlen_reg;
    logic [LW-1:0] len_reg;
    logic [AW-1:0] wp_reg;
    logic [SCW-1:0] spawn_reg;
    logic [PW-1:0] pos_reg [GRAIN_COUNT];
    logic [AGW-1:0] age_reg [GRAIN_COUNT];
    logic [GRAIN_COUNT-1:0] act_reg;
    logic [GW-1:0] g_reg;
    logic [1:0] tap_reg;
    logic [AW:0] clr_reg;
    logic signed [SampleWidth-1:0] smp_reg;
    logic signed [RatioWidth-1:0] ratio_reg;
    logic signed [SampleWidth-1:0] y_reg [4];
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] part_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [SampleWidth-1:0] out_reg;
    logic out_valid_reg;
    logic signed [31:0] ma_reg;
    logic signed [31:0] mb_reg;
    logic signed [SW-1:0] prod;
    logic [AW-1:0] rd_addr;
    logic out_load;

    assign cfg_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample_out = out_reg;
    assign prod = SW'(ma_reg) * SW'(mb_reg);
    assign out_load = (state_reg == ST_OUT) && !(out_valid_reg && out_stall);

    logic [LW-1:0] len_c;
    always_comb
    begin
        len_c = LW'(rlen_reg);
        if ({1'b0, rlen_reg} < 16'(2 * GRAIN_LENGTH))
        begin
            len_c = LW'(2 * GRAIN_LENGTH);
        end
        else if (32'(rlen_reg) > 32'(RING_DEPTH))
        begin
            len_c = LW'(RING_DEPTH);
        end
    end

    // Ring address of tap k around the grain index, wrapped into the length in use.
    logic [LW:0] idx_c;
    always_comb
    begin
        idx_c = (LW + 1)'(pos_reg[g_reg][PW-1:16]) + (LW + 1)'(len_reg) + (LW + 1)'(tap_reg)
            - (LW + 1)'(1);
        if (idx_c >= (LW + 1)'(len_reg))
        begin
            idx_c = idx_c - (LW + 1)'(len_reg);
        end
        if (idx_c >= (LW + 1)'(len_reg))
        begin
            idx_c = idx_c - (LW + 1)'(len_reg);
        end
        rd_addr = idx_c[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            ring_mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (state_reg == ST_PREP)
        begin
            ring_mem[wp_reg] <= smp_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // Catmull-Rom coefficients, doubled.
    logic signed [27:0] a0_c, a1_c, a2_c;
    logic signed [15:0] t_c;
    always_comb
    begin
        a0_c = -28'(y_reg[0]) + 28'sd3 * 28'(y_reg[1]) - 28'sd3 * 28'(y_reg[2]) + 28'(y_reg[3]);
        a1_c = 28'sd2 * 28'(y_reg[0]) - 28'sd5 * 28'(y_reg[1]) + 28'sd4 * 28'(y_reg[2])
            - 28'(y_reg[3]);
        a2_c = 28'(y_reg[2]) - 28'(y_reg[0]);
        t_c = 16'(pos_reg[g_reg][15:0]);
    end

    logic [GRAIN_COUNT-1:0] spawn_sel;
    always_comb
    begin
        spawn_sel = '0;
        for (int g = GRAIN_COUNT - 1; g >= 0; g--)
        begin
            if (!act_reg[g])
            begin
                spawn_sel = '0;
                spawn_sel[g] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (AW + 1)'(RING_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid && !in_stall) state_next = ST_PREP;
            ST_PREP:  state_next = ST_GRAIN;
            ST_GRAIN: state_next = act_reg[g_reg] ? ST_READ : ST_NEXT;
            ST_READ:  state_next = ST_WAIT;
            ST_WAIT:  state_next = (tap_reg == 2'd3) ? ST_CAPT : ST_WAIT;
            ST_CAPT:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_MUL4;
            ST_MUL4:  state_next = ST_MUL5;
            ST_MUL5:  state_next = ST_MUL6;
            ST_MUL6:  state_next = ST_MUL7;
            ST_MUL7:  state_next = ST_MUL8;
            ST_MUL8:  state_next = ST_MUL9;
            ST_MUL9:  state_next = ST_NEXT;
            ST_NEXT:  state_next = (32'(g_reg) == GRAIN_COUNT - 1) ? ST_OUT : ST_GRAIN;
            ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic signed [PW+2:0] np;
    logic signed [SW-1:0] y_round;
    always_comb
    begin
        np = (PW + 3)'(pos_reg[g_reg]) + (PW + 3)'(ratio_reg);
        if (np >= $signed((PW + 3)'({len_reg, 16'd0})))
        begin
            np = np - $signed((PW + 3)'({len_reg, 16'd0}));
        end
        if (np < 0)
        begin
            np = np + $signed((PW + 3)'({len_reg, 16'd0}));
        end
        y_round = (sum_reg + SW'(32768)) >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            rlen_reg <= RingLengthReset;
            wp_reg <= '0;
            spawn_reg <= '0;
            act_reg <= '0;
            out_valid_reg <= 1'b0;
            g_reg <= '0;
            tap_reg <= '0;
            len_reg <= '0;
            for (int g = 0; g < GRAIN_COUNT; g++)
            begin
                pos_reg[g] <= '0;
                age_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                rlen_reg <= ring_length;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    smp_reg <= sample_in;
                    ratio_reg <= pitch_ratio;
                    len_reg <= len_c;
                    if (in_valid && !in_stall)
                    begin
                        if (LW'(wp_reg) >= len_c)
                        begin
                            wp_reg <= '0;
                        end
                        for (int g = 0; g < GRAIN_COUNT; g++)
                        begin
                            if (act_reg[g] && (SPW'(pos_reg[g]) >= SPW'({len_c, 16'd0})))
                            begin
                                pos_reg[g] <= '0;
                            end
                        end
                    end
                end
                ST_PREP:
                begin
                    sum_reg <= '0;
                    g_reg <= '0;
                    tap_reg <= '0;
                    if (32'(spawn_reg) + 1 >= GRAIN_LENGTH / 2)
                    begin
                        spawn_reg <= '0;
                        for (int g = 0; g < GRAIN_COUNT; g++)
                        begin
                            if (spawn_sel[g])
                            begin
                                act_reg[g] <= 1'b1;
                                age_reg[g] <= '0;
                                if (32'(wp_reg) >= 2 * GRAIN_LENGTH)
                                begin
                                    pos_reg[g] <= {wp_reg - AW'(2 * GRAIN_LENGTH), 16'd0};
                                end
                                else
                                begin
                                    pos_reg[g] <= {AW'(LW'(wp_reg) + len_reg
                                        - LW'(2 * GRAIN_LENGTH)), 16'd0};
                                end
                            end
                        end
                    end
                    else
                    begin
                        spawn_reg <= spawn_reg + 1'b1;
                    end
                end
                ST_GRAIN:
                begin
                    tap_reg <= 2'd1;
                end
                ST_READ:
                begin
                    tap_reg <= 2'd2;
                    y_reg[0] <= rd_data_reg;
                end
                ST_WAIT:
                begin
                    tap_reg <= tap_reg + 1'b1;
                    y_reg[tap_reg - 2'd1] <= rd_data_reg;
                end
                ST_CAPT:
                begin
                    y_reg[3] <= rd_data_reg;
                    tap_reg <= '0;
                end
                ST_MUL1:
                begin
                    ma_reg <= 32'(a0_c);
                    mb_reg <= 32'({16'd0, t_c});
                end
                ST_MUL2:
                begin
                    acc_reg <= prod + (SW'(a1_c) <<< 16);
                end
                ST_MUL3:
                begin
                    ma_reg <= 32'(acc_reg >>> 16);
                    mb_reg <= 32'({16'd0, t_c});
                end
                ST_MUL4:
                begin
                    part_reg <= prod;
                    ma_reg <= 32'({16'd0, acc_reg[15:0]});
                end
                ST_MUL5:
                begin
                    acc_reg <= part_reg + (prod >>> 16) + (SW'(a2_c) <<< 16);
                end
                ST_MUL6:
                begin
                    ma_reg <= 32'(acc_reg >>> 16);
                end
                ST_MUL7:
                begin
                    part_reg <= prod;
                    ma_reg <= 32'({16'd0, acc_reg[15:0]});
                end
                ST_MUL8:
                begin
                    acc_reg <= SW'(y_reg[1])
                        + (((part_reg <<< 16) + prod + (SW'(1) <<< 32)) >>> 33);
                end
                ST_MUL9:
                begin
                    ma_reg <= 32'(acc_reg);
                    mb_reg <= 32'({15'd0, hann_rom[age_reg[g_reg][HW-1:0]]});
                end
                ST_NEXT:
                begin
                    if (act_reg[g_reg])
                    begin
                        if (32'(age_reg[g_reg]) < GRAIN_LENGTH)
                        begin
                            sum_reg <= sum_reg + prod;
                        end
                        age_reg[g_reg] <= age_reg[g_reg] + 1'b1;
                        pos_reg[g_reg] <= PW'(np);
                        if (32'(age_reg[g_reg]) + 1 >= GRAIN_LENGTH)
                        begin
                            act_reg[g_reg] <= 1'b0;
                        end
                    end
                    g_reg <= g_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        wp_reg <= (LW'(wp_reg) + 1'b1 >= len_reg) ? '0 : wp_reg + 1'b1;
                        if (y_round > SW'(8388607))
                        begin
                            out_reg <= 24'sh7FFFFF;
                        end
                        else if (y_round < -SW'(8388608))
                        begin
                            out_reg <= -24'sh800000;
                        end
                        else
                        begin
                            out_reg <= y_round[SampleWidth-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import gps_pkg::*;

    localparam int GrainLen   = GrainLengthDef;
    localparam int GrainCnt   = GrainCountDef;
    localparam int RingDepth  = RingDepthDef;
    localparam int DrainWait  = 60;
    localparam int IdleLimit  = 100000;
    localparam int HoldCycles = 400;

    typedef struct packed {
        logic signed [SampleWidth-1:0] smp;
        logic signed [RatioWidth-1:0]  ratio;
    } audio_item_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CfgWidth-1:0] ring_length;
    logic in_valid;
    logic in_stall;
    logic signed [SampleWidth-1:0] sample_in;
    logic signed [RatioWidth-1:0] pitch_ratio;
    logic out_valid;
    logic out_stall;
    logic signed [SampleWidth-1:0] sample_out;

    audio_item_t pending_samples[$];
    logic signed [SampleWidth-1:0] expected_out[$];
    int errors = 0;
    logic hold_off = 1'b0;

    // Shifter model state.
    logic [16:0] win_rom[GrainLen];
    int unsigned model_len_cfg;
    longint ring_mem[RingDepth];
    int unsigned wr_ptr;
    int unsigned spawn_cnt;
    longint grain_pos[GrainCnt];
    int unsigned grain_age[GrainCnt];
    bit grain_on[GrainCnt];

    granular_pitch_shifter dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .ring_length(ring_length),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .pitch_ratio(pitch_ratio),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void build_window();
        logic [63:0] p, u, z, z2, acc, s, w;
        for (int i = 0; i < GrainLen; i++)
        begin
            p = (64'(i) << 30) / 64'(GrainLen - 1);
            u = (p > 64'd536870912) ? (64'd1073741824 - p) : p;
            z = u << 1;
            z2 = (z * z) >> 30;
            acc = 64'd5026994 - ((z2 * 64'd172273) >> 30);
            acc = 64'd85569306 - ((z2 * acc) >> 30);
            acc = 64'd693598670 - ((z2 * acc) >> 30);
            acc = 64'd1686629713 - ((z2 * acc) >> 30);
            s = (z * acc) >> 30;
            w = (s * s + (64'd1 << 43)) >> 44;
            if (w > 64'd65536)
            begin
                w = 64'd65536;
            end
            win_rom[i] = w[16:0];
        end
    endfunction

    function automatic longint cubic_value(longint pos, int unsigned len);
        int unsigned idx;
        longint t, y0, y1, y2, y3, a0, a1, a2, v, h;
        idx = int'(pos >> 16);
        t = pos & 64'hFFFF;
        y0 = ring_mem[(idx + len - 1) % len];
        y1 = ring_mem[idx % len];
        y2 = ring_mem[(idx + 1) % len];
        y3 = ring_mem[(idx + 2) % len];
        a0 = -y0 + 3 * y1 - 3 * y2 + y3;
        a1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        a2 = y2 - y0;
        v = ((a0 * t + a1 * 65536) * t) >>> 16;
        h = ((v + a2 * 65536) * t + (64'sd1 <<< 32)) >>> 33;
        return y1 + h;
    endfunction

    function automatic logic signed [SampleWidth-1:0] shift_sample(audio_item_t it);
        int unsigned len;
        longint span, ratio, acc, p, start, y;
        len = model_len_cfg;
        if (len < 2 * GrainLen)
        begin
            len = 2 * GrainLen;
        end
        if (len > RingDepth)
        begin
            len = RingDepth;
        end
        span = longint'(len) << 16;
        ratio = longint'(it.ratio);
        acc = 0;
        if (wr_ptr >= len)
        begin
            wr_ptr = 0;
        end
        for (int g = 0; g < GrainCnt; g++)
        begin
            if (grain_on[g] && grain_pos[g] >= span)
            begin
                grain_pos[g] = 0;
            end
        end
        ring_mem[wr_ptr] = longint'(it.smp);
        spawn_cnt++;
        if (spawn_cnt >= GrainLen / 2)
        begin
            spawn_cnt = 0;
            for (int g = 0; g < GrainCnt; g++)
            begin
                if (!grain_on[g])
                begin
                    start = longint'(wr_ptr) - 2 * GrainLen;
                    if (start < 0)
                    begin
                        start += len;
                    end
                    grain_on[g] = 1'b1;
                    grain_age[g] = 0;
                    grain_pos[g] = start << 16;
                    break;
                end
            end
        end
        for (int g = 0; g < GrainCnt; g++)
        begin
            if (grain_on[g])
            begin
                if (grain_age[g] < GrainLen)
                begin
                    acc += cubic_value(grain_pos[g], len) * longint'(win_rom[grain_age[g]]);
                end
                grain_age[g]++;
                p = grain_pos[g] + ratio;
                if (p >= span)
                begin
                    p -= span;
                end
                if (p < 0)
                begin
                    p += span;
                end
                grain_pos[g] = p;
                if (grain_age[g] >= GrainLen)
                begin
                    grain_on[g] = 1'b0;
                end
            end
        end
        wr_ptr = (wr_ptr + 1) % len;
        y = (acc + 32768) >>> 16;
        if (y > 8388607)
        begin
            y = 8388607;
        end
        if (y < -8388608)
        begin
            y = -8388608;
        end
        return y[SampleWidth-1:0];
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_in <= '0;
            pitch_ratio <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_out.push_back(shift_sample({sample_in, pitch_ratio}));
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_samples.size() > 0)
                begin
                    {sample_in, pitch_ratio} <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks results and stalls on its own pattern.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SampleWidth-1:0] want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("sample_out: unexpected transfer, actual %0d", sample_out);
                    errors++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (want !== sample_out)
                    begin
                        $error("sample_out: expected %0d, actual %0d", want, sample_out);
                        errors++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 400);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= hold_off;
                1: out_stall <= hold_off || ($urandom_range(0, 3) == 0);
                2: out_stall <= hold_off || ($urandom_range(0, 1) == 0);
                default: out_stall <= hold_off || ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Long receiver hold-off so that the block backs up into its input.
    initial
    begin
        repeat (RingDepth + 3000) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
    end

    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit)
        begin
            $display("FAIL granular_pitch_shifter");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_valid || expected_out.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DrainWait) @(posedge clk);
    endtask

    task automatic write_length(int unsigned value);
        wait_drained();
        cfg_valid <= 1'b1;
        ring_length <= value[CfgWidth-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        model_len_cfg = value & 32'h7FFF;
        cfg_valid <= 1'b0;
    endtask

    function automatic audio_item_t random_sample();
        audio_item_t it;
        int unsigned pick;
        it.smp = SampleWidth'($urandom());
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            it.smp = 24'sh7FFFFF;
        end
        else if (pick == 1)
        begin
            it.smp = 24'sh800000;
        end
        pick = $urandom_range(0, 7);
        if (pick < 4)
        begin
            it.ratio = RatioWidth'($urandom_range(32768, 131072));
        end
        else if (pick < 6)
        begin
            it.ratio = RatioWidth'($urandom());
        end
        else
        begin
            it.ratio = -RatioWidth'($urandom_range(1, 131072));
        end
        return it;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            pending_samples.push_back(random_sample());
        end
    endtask

    initial
    begin
        logic signed [SampleWidth-1:0] smp_edges[4];
        logic signed [RatioWidth-1:0] ratio_edges[6];
        smp_edges = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh000001};
        ratio_edges = '{20'sh7FFFF, 20'sh80000, 20'sh00000, 20'sh10000, -20'sh10000, 20'sh00001};
        build_window();
        model_len_cfg = RingLengthReset;
        wr_ptr = 0;
        spawn_cnt = 0;
        for (int i = 0; i < RingDepth; i++)
        begin
            ring_mem[i] = 0;
        end
        for (int g = 0; g < GrainCnt; g++)
        begin
            grain_pos[g] = 0;
            grain_age[g] = 0;
            grain_on[g] = 1'b0;
        end
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        ring_length = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 24; i++)
        begin
            pending_samples.push_back({smp_edges[i % 4], ratio_edges[i % 6]});
        end
        random_phase(200);
        write_length(16384);
        random_phase(260);
        // Shrinking the ring leaves the write point and live grains past the end.
        write_length(2048);
        random_phase(150);
        write_length(100);
        random_phase(120);
        write_length(32767);
        random_phase(150);
        write_length(4096);
        random_phase(120);
        write_length(9600);
        random_phase(100);
        wait_drained();
        if (errors == 0)
        begin
            $display("PASS granular_pitch_shifter");
        end
        else
        begin
            $display("FAIL granular_pitch_shifter");
        end
        $finish;
    end

endmodule
